// ----- rtl/shmu_pkg.sv -----
// shower moments unit: shared constants, widths, command and result types
// no dependencies; every other file in rtl uses this package
package shmu_pkg;

   // geometry and energy format
   localparam int LAYERS      = 14;
   localparam int BARS        = 32;
   localparam int ENERGY_BITS = 24;

   localparam int BAR_IDX_W   = (BARS > 1) ? $clog2(BARS) : 1;
   localparam int BAR_SLOTS   = 1 << BAR_IDX_W;
   localparam int LAYER_IDX_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int ADDR_W      = LAYER_IDX_W + BAR_IDX_W;
   localparam int MEM_DEPTH   = LAYERS * BAR_SLOTS;

   // internal arithmetic widths
   localparam int COUNT_W  = $clog2(BARS + 1);
   localparam int SUM_E_W  = ENERGY_BITS + COUNT_W;
   localparam int SUM_BE_W = ENERGY_BITS + BAR_IDX_W + COUNT_W;
   localparam int POS_W    = BAR_IDX_W + 8;
   localparam int DSQ_W    = 2 * POS_W;
   localparam int PROD_W   = ENERGY_BITS + DSQ_W;
   localparam int ACC_W    = PROD_W + COUNT_W;
   localparam int DEN_P_W  = ENERGY_BITS + 2;

   // serial divider
   localparam int DIV_NUM_W = ACC_W;
   localparam int DIV_DEN_W = SUM_E_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // port field widths
   localparam int OP_W       = 2;
   localparam int HIT_LYR_W  = 4;
   localparam int HIT_BAR_W  = 5;
   localparam int HIT_E_W    = 24;
   localparam int LAYER_F_W  = 4;
   localparam int FIRED_F_W  = 6;
   localparam int LAYER_E_W  = 29;
   localparam int MAXB_F_W   = 5;
   localparam int PEAK_W     = 17;
   localparam int CENTRE_W   = 13;
   localparam int SPREAD_W   = 18;
   localparam int SUM33_W    = 33;
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [63:0] LAYER_E_MAX = 64'd536870911;
   localparam logic [63:0] CENTRE_MAX  = 64'd8191;
   localparam logic [63:0] SPREAD_MAX  = 64'd262143;

   localparam logic [CFG_W-1:0] LAST_LAYER_RESET = 4'd13;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DROP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST  = 2'd2;

   // operation codes on the request channel
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_ADD,
      CMD_REPORT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                  kind;
      logic [LAYER_IDX_W-1:0]        layer;
      logic [BAR_IDX_W-1:0]          bar;
      logic [ENERGY_BITS-1:0]        energy;
   } cmd_type;

   typedef struct packed {
      logic                          drop_isolated_bars;
      logic [CFG_W-1:0]              first_layer;
      logic [CFG_W-1:0]              last_layer;
   } cfg_type;

   // per-layer result held until the report streams out
   typedef struct packed {
      logic [FIRED_F_W-1:0]          fired_count;
      logic [LAYER_E_W-1:0]          layer_energy;
      logic [MAXB_F_W-1:0]           max_bar;
      logic [PEAK_W-1:0]             peak_ratio;
      logic [CENTRE_W-1:0]           centre_bar;
      logic [SPREAD_W-1:0]           spread;
      logic                          layer_valid;
   } res_type;

   // queue status seen by the back end
   typedef struct packed {
      logic                          empty;
      logic                          full;
   } q_stat_type;

endpackage

// ----- rtl/shmu_if.sv -----
// shower moments unit: request and result channel interfaces
// depends on shmu_pkg for field widths
interface shmu_req_if;
   logic                               valid;
   logic                               ready;
   logic [shmu_pkg::OP_W-1:0]          operation;
   logic [shmu_pkg::HIT_LYR_W-1:0]     hit_layer;
   logic [shmu_pkg::HIT_BAR_W-1:0]     hit_bar;
   logic [shmu_pkg::HIT_E_W-1:0]       hit_energy;

   modport source (output valid, operation, hit_layer, hit_bar, hit_energy, input ready);
   modport sink   (input valid, operation, hit_layer, hit_bar, hit_energy, output ready);
endinterface

interface shmu_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [shmu_pkg::LAYER_F_W-1:0]     layer_index;
   logic [shmu_pkg::FIRED_F_W-1:0]     fired_count;
   logic [shmu_pkg::LAYER_E_W-1:0]     layer_energy;
   logic [shmu_pkg::MAXB_F_W-1:0]      max_bar;
   logic [shmu_pkg::PEAK_W-1:0]        peak_ratio;
   logic [shmu_pkg::CENTRE_W-1:0]      centre_bar;
   logic [shmu_pkg::SPREAD_W-1:0]      spread;
   logic                               layer_valid;
   logic [shmu_pkg::SUM33_W-1:0]       range_energy;
   logic [shmu_pkg::SUM33_W-1:0]       event_energy;
   logic                               last;

   modport source (output valid, layer_index, fired_count, layer_energy, max_bar, peak_ratio,
                   centre_bar, spread, layer_valid, range_energy, event_energy, last,
                   input ready);
   modport sink   (input valid, layer_index, fired_count, layer_energy, max_bar, peak_ratio,
                   centre_bar, spread, layer_valid, range_energy, event_energy, last,
                   output ready);
endinterface

// ----- rtl/shmu_front.sv -----
// shower moments unit: front end, accepts request items and classifies them
// depends on shmu_pkg and shmu_req_if
module shmu_front (
   shmu_req_if.sink              req_chan,
   input  shmu_pkg::q_stat_type  q_stat,
   output logic                  push,
   output shmu_pkg::cmd_type     push_cmd
);
   import shmu_pkg::*;

   logic in_range;
   logic keep;

   // hits outside the store and the unused operation code are dropped here
   always_comb begin
      in_range = (32'(req_chan.hit_layer) < LAYERS) && (32'(req_chan.hit_bar) < BARS);
      keep     = 1'b0;
      push_cmd.kind   = CMD_CLEAR;
      push_cmd.layer  = LAYER_IDX_W'(req_chan.hit_layer);
      push_cmd.bar    = BAR_IDX_W'(req_chan.hit_bar);
      push_cmd.energy = req_chan.hit_energy[ENERGY_BITS-1:0];
      unique case (req_chan.operation)
         OP_CLEAR: begin
            push_cmd.kind = CMD_CLEAR;
            keep = 1'b1;
         end
         OP_ADD: begin
            push_cmd.kind = CMD_ADD;
            keep = in_range;
         end
         OP_REPORT: begin
            push_cmd.kind = CMD_REPORT;
            keep = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_chan.ready = !q_stat.full;
   assign push = req_chan.valid && req_chan.ready && keep;

endmodule

// ----- rtl/shmu_queue.sv -----
// shower moments unit: short command queue between front and back end
// depends on shmu_pkg
module shmu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  shmu_pkg::cmd_type     push_cmd,
   input  logic                  pop,
   output shmu_pkg::cmd_type     pop_cmd,
   output shmu_pkg::q_stat_type  q_stat
);
   import shmu_pkg::*;

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QPTR_W:0]       count_ff;

   // storage, written at the tail
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         priority if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign pop_cmd      = slot_ff[rd_ptr_ff];
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));

endmodule

// ----- rtl/shmu_div.sv -----
// shower moments unit: shared restoring divider, one quotient bit per cycle
// depends on shmu_pkg
module shmu_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [shmu_pkg::DIV_NUM_W-1:0]   num,
   input  logic [shmu_pkg::DIV_DEN_W-1:0]   den,
   output logic                             busy,
   output logic                             done,
   output logic [shmu_pkg::DIV_NUM_W-1:0]   quo
);
   import shmu_pkg::*;

   logic [DIV_NUM_W-1:0]  work_ff;
   logic [DIV_DEN_W-1:0]  rem_ff;
   logic [DIV_DEN_W-1:0]  den_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_DEN_W:0]    trial;
   logic [DIV_DEN_W:0]    diff;
   logic                  ge;

   // one shift-subtract step
   always_comb begin
      trial = {rem_ff, work_ff[DIV_NUM_W-1]};
      ge    = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1));
         if (start) begin
            work_ff <= num;
            rem_ff  <= '0;
            den_ff  <= den;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            work_ff <= {work_ff[DIV_NUM_W-2:0], ge};
            rem_ff  <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = work_ff;

endmodule

// ----- rtl/shmu_engine.sv -----
// shower moments unit: back end with the bar energy store, the layer
// sequencer and the result register; depends on shmu_pkg, shmu_rsp_if, shmu_div
module shmu_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  shmu_pkg::cfg_type     cfg,
   input  shmu_pkg::cmd_type     q_cmd,
   input  shmu_pkg::q_stat_type  q_stat,
   output logic                  q_pop,
   shmu_rsp_if.source            rsp_chan
);
   import shmu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ADD_WR, S_SCAN, S_DRAIN, S_NBR_LO, S_NBR_HI, S_NBR_END, S_DIVP,
      S_DIVC_GO, S_DIVC, S_SPREAD, S_SPREAD_DRAIN, S_DIVS, S_STORE, S_EMIT
   } state_type;

   state_type                 state_ff;

   // bar energy store; an entry counts only while its fired bit is set
   logic [ENERGY_BITS-1:0]    mem [MEM_DEPTH];
   logic [ENERGY_BITS-1:0]    rd_data_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      wr_en;
   logic [ENERGY_BITS-1:0]    wr_data;

   logic [BAR_SLOTS-1:0]      fired_ff [LAYERS];
   logic [SUM33_W-1:0]        event_ff;

   // command being carried out
   logic [LAYER_IDX_W-1:0]    cmd_layer_ff;
   logic [BAR_IDX_W-1:0]      cmd_bar_ff;
   logic [ENERGY_BITS-1:0]    cmd_energy_ff;

   // layer walk
   logic [LAYER_IDX_W-1:0]    layer_ff;
   logic [BAR_IDX_W-1:0]      bar_ff;
   logic [BAR_IDX_W-1:0]      pb_ff;
   logic                      pv_ff;
   logic                      pvs_ff;
   logic [1:0]                drain_ff;

   // scan accumulators
   logic [COUNT_W-1:0]        count_ff;
   logic [SUM_E_W-1:0]        sum_e_ff;
   logic [SUM_BE_W-1:0]       sum_be_ff;
   logic [ENERGY_BITS-1:0]    best_ff;
   logic [BAR_IDX_W-1:0]      maxb_ff;
   logic                      found_ff;
   logic [ENERGY_BITS-1:0]    e_lo_ff;

   // moment results of the current layer
   logic [PEAK_W-1:0]         peak_ff;
   logic [POS_W-1:0]          c_ff;
   logic [CENTRE_W-1:0]       centre_ff;
   logic [SPREAD_W-1:0]       spread_ff;

   // spread pipeline
   logic                      v2_ff;
   logic [ENERGY_BITS-1:0]    e2_ff;
   logic [DSQ_W-1:0]          dsq2_ff;
   logic                      v3_ff;
   logic [PROD_W-1:0]         p3_ff;
   logic [ACC_W-1:0]          acc_ff;

   // report buffer and output register
   res_type                   res_ff [LAYERS];
   logic [SUM33_W-1:0]        range_ff;
   logic [LAYER_IDX_W-1:0]    emit_ff;
   logic                      out_v_ff;
   res_type                   out_res_ff;
   logic [LAYER_F_W-1:0]      out_layer_ff;
   logic [SUM33_W-1:0]        out_range_ff;
   logic [SUM33_W-1:0]        out_event_ff;
   logic                      out_last_ff;

   // combinational helpers
   logic [BAR_SLOTS-1:0]      raw;
   logic [BAR_SLOTS-1:0]      filt;
   logic                      old_fired;
   logic [ENERGY_BITS-1:0]    old_e;
   logic [ENERGY_BITS:0]      add_sum;
   logic [ENERGY_BITS-1:0]    new_e;
   logic [SUM33_W:0]          ev_sum;
   logic [ENERGY_BITS-1:0]    e_cur;
   logic [ENERGY_BITS+BAR_IDX_W-1:0] bprod;
   logic [ENERGY_BITS-1:0]    e_hi;
   logic [DEN_P_W-1:0]        den_p;
   logic [POS_W-1:0]          pos;
   logic [POS_W-1:0]          pos_dev;
   logic [SUM33_W:0]          rng_sum;
   logic                      in_rng;
   logic                      div_start;
   logic [DIV_NUM_W-1:0]      div_num;
   logic [DIV_DEN_W-1:0]      div_den;
   logic                      div_busy;
   logic                      div_done;
   logic [DIV_NUM_W-1:0]      div_quo;
   logic [DIV_NUM_W-1:0]      spread_q;
   logic                      emit_load;
   res_type                   cur_res;

   shmu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   // fired pattern of the current layer and its isolation filter
   always_comb begin
      raw  = fired_ff[layer_ff];
      filt = cfg.drop_isolated_bars ? (raw & ((raw << 1) | (raw >> 1))) : raw;
   end

   // hit accumulation with saturation, and the event sum it changes
   always_comb begin
      old_fired = fired_ff[cmd_layer_ff][cmd_bar_ff];
      old_e     = old_fired ? rd_data_ff : '0;
      add_sum   = {1'b0, old_e} + {1'b0, cmd_energy_ff};
      new_e     = add_sum[ENERGY_BITS] ? '1 : add_sum[ENERGY_BITS-1:0];
      ev_sum    = {1'b0, event_ff} + (SUM33_W + 1)'(new_e - old_e);
   end

   // energy of the bar whose read data is present, and datapath terms
   always_comb begin
      e_cur = raw[pb_ff] ? rd_data_ff : '0;
      bprod = pb_ff * e_cur;
      e_hi  = ((maxb_ff != BAR_IDX_W'(BARS - 1)) && raw[maxb_ff + 1'b1]) ? rd_data_ff : '0;
      den_p = DEN_P_W'(best_ff) + DEN_P_W'(e_lo_ff) + DEN_P_W'(e_hi);
      pos   = {pb_ff, 8'b0};
      pos_dev = (pos >= c_ff) ? (pos - c_ff) : (c_ff - pos);
      in_rng  = (32'(layer_ff) >= 32'(cfg.first_layer)) && (32'(layer_ff) <= 32'(cfg.last_layer));
      rng_sum = {1'b0, range_ff} + (SUM33_W + 1)'(sum_e_ff);
      spread_q = div_quo >> 8;
   end

   // store address, write port and divider operands by state
   always_comb begin
      rd_addr   = {cmd_layer_ff, cmd_bar_ff};
      wr_en     = 1'b0;
      wr_data   = new_e;
      div_start = 1'b0;
      div_num   = DIV_NUM_W'({best_ff, 16'b0});
      div_den   = DIV_DEN_W'(den_p);
      unique case (state_ff)
         S_IDLE:    rd_addr = {q_cmd.layer, q_cmd.bar};
         S_ADD_WR:  wr_en = 1'b1;
         S_SCAN, S_SPREAD: rd_addr = {layer_ff, bar_ff};
         S_NBR_LO:  rd_addr = {layer_ff, maxb_ff - 1'b1};
         S_NBR_HI:  rd_addr = {layer_ff, maxb_ff + 1'b1};
         S_NBR_END: div_start = found_ff && (den_p != '0);
         S_DIVC_GO: begin
            div_start = (count_ff != '0) && (sum_e_ff != '0);
            div_num   = DIV_NUM_W'({sum_be_ff, 8'b0});
            div_den   = DIV_DEN_W'(sum_e_ff);
         end
         S_SPREAD_DRAIN: begin
            div_start = (drain_ff == 2'd3);
            div_num   = DIV_NUM_W'(acc_ff);
            div_den   = DIV_DEN_W'(sum_e_ff);
         end
         default: wr_en = 1'b0;
      endcase
   end

   assign q_pop = (state_ff == S_IDLE) && !q_stat.empty;

   // result of the current layer as stored for the report
   always_comb begin
      cur_res.fired_count  = FIRED_F_W'(count_ff);
      cur_res.layer_energy = (64'(sum_e_ff) > LAYER_E_MAX) ? LAYER_E_MAX[LAYER_E_W-1:0]
                                                           : LAYER_E_W'(sum_e_ff);
      cur_res.max_bar      = MAXB_F_W'(maxb_ff);
      cur_res.peak_ratio   = peak_ff;
      cur_res.centre_bar   = centre_ff;
      cur_res.spread       = spread_ff;
      cur_res.layer_valid  = (count_ff != '0);
   end

   assign emit_load = (state_ff == S_EMIT) && (!out_v_ff || rsp_chan.ready);

   // energy store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{cmd_layer_ff, cmd_bar_ff}] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // spread datapath: distance squared, weighted term, sum
   always_ff @(posedge clock) begin
      v2_ff   <= pvs_ff && filt[pb_ff];
      e2_ff   <= e_cur;
      dsq2_ff <= pos_dev * pos_dev;
      v3_ff   <= v2_ff;
      p3_ff   <= e2_ff * dsq2_ff;
      if (state_ff == S_DIVC) begin
         acc_ff <= '0;
      end else if (v3_ff) begin
         acc_ff <= acc_ff + ACC_W'(p3_ff);
      end
   end

   // sequencer with its registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         event_ff <= '0;
         out_v_ff <= 1'b0;
         pv_ff    <= 1'b0;
         pvs_ff   <= 1'b0;
         for (int l = 0; l < LAYERS; l++) begin
            fired_ff[l] <= '0;
         end
      end else begin
         pv_ff  <= (state_ff == S_SCAN);
         pvs_ff <= (state_ff == S_SPREAD);
         pb_ff  <= bar_ff;

         // scan accumulation in the cycle after the read
         if (pv_ff) begin
            if (raw[pb_ff] && (!found_ff || (e_cur > best_ff))) begin
               best_ff  <= e_cur;
               maxb_ff  <= pb_ff;
               found_ff <= 1'b1;
            end
            if (filt[pb_ff]) begin
               count_ff  <= count_ff + 1'b1;
               sum_e_ff  <= sum_e_ff + SUM_E_W'(e_cur);
               sum_be_ff <= sum_be_ff + SUM_BE_W'(bprod);
            end
         end

         // output register: loaded by the emit walk, freed when taken
         if (emit_load) begin
            out_v_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_v_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  cmd_layer_ff  <= q_cmd.layer;
                  cmd_bar_ff    <= q_cmd.bar;
                  cmd_energy_ff <= q_cmd.energy;
                  unique case (q_cmd.kind)
                     CMD_CLEAR: begin
                        event_ff <= '0;
                        for (int l = 0; l < LAYERS; l++) begin
                           fired_ff[l] <= '0;
                        end
                     end
                     CMD_ADD: state_ff <= S_ADD_WR;
                     CMD_REPORT: begin
                        layer_ff  <= '0;
                        bar_ff    <= '0;
                        range_ff  <= '0;
                        count_ff  <= '0;
                        sum_e_ff  <= '0;
                        sum_be_ff <= '0;
                        best_ff   <= '0;
                        maxb_ff   <= '0;
                        found_ff  <= 1'b0;
                        state_ff  <= S_SCAN;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_ADD_WR: begin
               fired_ff[cmd_layer_ff][cmd_bar_ff] <= 1'b1;
               event_ff <= ev_sum[SUM33_W] ? '1 : ev_sum[SUM33_W-1:0];
               state_ff <= S_IDLE;
            end
            S_SCAN: begin
               bar_ff <= bar_ff + 1'b1;
               if (bar_ff == BAR_IDX_W'(BARS - 1)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN:  state_ff <= S_NBR_LO;
            S_NBR_LO: state_ff <= S_NBR_HI;
            S_NBR_HI: begin
               e_lo_ff  <= ((maxb_ff != '0) && raw[maxb_ff - 1'b1]) ? rd_data_ff : '0;
               state_ff <= S_NBR_END;
            end
            S_NBR_END: begin
               peak_ff  <= '0;
               state_ff <= div_start ? S_DIVP : S_DIVC_GO;
            end
            S_DIVP: begin
               if (div_done) begin
                  peak_ff  <= PEAK_W'(div_quo);
                  state_ff <= S_DIVC_GO;
               end
            end
            S_DIVC_GO: begin
               centre_ff <= '0;
               spread_ff <= '0;
               state_ff  <= div_start ? S_DIVC : S_STORE;
            end
            S_DIVC: begin
               if (div_done) begin
                  c_ff      <= POS_W'(div_quo);
                  centre_ff <= (64'(div_quo) > CENTRE_MAX) ? CENTRE_MAX[CENTRE_W-1:0]
                                                           : CENTRE_W'(div_quo);
                  bar_ff    <= '0;
                  state_ff  <= S_SPREAD;
               end
            end
            S_SPREAD: begin
               bar_ff <= bar_ff + 1'b1;
               if (bar_ff == BAR_IDX_W'(BARS - 1)) begin
                  drain_ff <= '0;
                  state_ff <= S_SPREAD_DRAIN;
               end
            end
            S_SPREAD_DRAIN: begin
               drain_ff <= drain_ff + 1'b1;
               if (div_start) begin
                  state_ff <= S_DIVS;
               end
            end
            S_DIVS: begin
               if (div_done) begin
                  spread_ff <= (64'(spread_q) > SPREAD_MAX) ? SPREAD_MAX[SPREAD_W-1:0]
                                                            : SPREAD_W'(spread_q);
                  state_ff  <= S_STORE;
               end
            end
            S_STORE: begin
               res_ff[layer_ff] <= cur_res;
               if (in_rng) begin
                  range_ff <= rng_sum[SUM33_W] ? '1 : rng_sum[SUM33_W-1:0];
               end
               count_ff  <= '0;
               sum_e_ff  <= '0;
               sum_be_ff <= '0;
               best_ff   <= '0;
               maxb_ff   <= '0;
               found_ff  <= 1'b0;
               bar_ff    <= '0;
               if (layer_ff == LAYER_IDX_W'(LAYERS - 1)) begin
                  emit_ff  <= '0;
                  state_ff <= S_EMIT;
               end else begin
                  layer_ff <= layer_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            S_EMIT: begin
               if (emit_load) begin
                  out_res_ff   <= res_ff[emit_ff];
                  out_layer_ff <= LAYER_F_W'(emit_ff);
                  out_range_ff <= range_ff;
                  out_event_ff <= event_ff;
                  out_last_ff  <= (emit_ff == LAYER_IDX_W'(LAYERS - 1));
                  emit_ff      <= emit_ff + 1'b1;
                  if (emit_ff == LAYER_IDX_W'(LAYERS - 1)) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result channel
   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.layer_index  = out_layer_ff;
   assign rsp_chan.fired_count  = out_res_ff.fired_count;
   assign rsp_chan.layer_energy = out_res_ff.layer_energy;
   assign rsp_chan.max_bar      = out_res_ff.max_bar;
   assign rsp_chan.peak_ratio   = out_res_ff.peak_ratio;
   assign rsp_chan.centre_bar   = out_res_ff.centre_bar;
   assign rsp_chan.spread       = out_res_ff.spread;
   assign rsp_chan.layer_valid  = out_res_ff.layer_valid;
   assign rsp_chan.range_energy = out_range_ff;
   assign rsp_chan.event_energy = out_event_ff;
   assign rsp_chan.last         = out_last_ff;

`ifndef SYNTHESIS
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_clear_event: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (q_cmd.kind == CMD_CLEAR)) |=> (event_ff == '0))
      else $error("event sum not cleared");

   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE) |-> (peak_ff <= 17'd65536))
      else $error("peak ratio above one");
`endif

endmodule

// ----- rtl/calorimeter_layer_shower_moments_unit.sv -----
// shower moments unit: top level with configuration registers
// depends on shmu_pkg, shmu_if, shmu_front, shmu_queue, shmu_engine
//
// Request items enter through a front end that takes one item per cycle while
// its four-entry command queue has room; operation 3 and hits outside the
// store are dropped there. The back end takes one command at a time: a clear
// needs no clearing pass, since the store is qualified by per-bar fired bits,
// and a hit is a read followed by a saturating write of the store. A report
// walks each layer over the single store port (a scan of BARS reads, two
// neighbour reads and, when the layer has energy, a spread walk of BARS reads)
// with up to three divisions on one shared serial divider, before its 14 result
// items stream out, one per cycle when the result side is ready. Hits queued
// behind a report wait for it.
module calorimeter_layer_shower_moments_unit (
   input  logic                            clock,
   input  logic                            reset,
   shmu_req_if.sink                        req_chan,
   shmu_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [shmu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [shmu_pkg::CFG_W-1:0]      csr_wdata
);
   import shmu_pkg::*;

   cfg_type     cfg_ff;
   logic        push;
   cmd_type     push_cmd;
   logic        q_pop;
   cmd_type     q_cmd;
   q_stat_type  q_stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drop_isolated_bars <= 1'b0;
         cfg_ff.first_layer        <= '0;
         cfg_ff.last_layer         <= LAST_LAYER_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DROP:  cfg_ff.drop_isolated_bars <= csr_wdata[0];
            CSR_FIRST: cfg_ff.first_layer        <= csr_wdata;
            CSR_LAST:  cfg_ff.last_layer         <= csr_wdata;
            default:   cfg_ff <= cfg_ff;
         endcase
      end
   end

   shmu_front u_front (
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   shmu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (q_cmd),
      .q_stat   (q_stat)
   );

   shmu_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_cmd    (q_cmd),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- tb/calorimeter_layer_shower_moments_unit_tb.sv -----
// shower moments unit testbench: hit collection, per-layer reports and csr settings
// depends on rtl/shmu_pkg.sv, rtl/shmu_if.sv and the calorimeter_layer_shower_moments_unit rtl
module calorimeter_layer_shower_moments_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import shmu_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam longint unsigned SUM33_MAX    = 64'h1_FFFF_FFFF;
   localparam longint unsigned RUN_LIMIT    = 2000000;

   typedef struct {
      logic [LAYER_F_W-1:0] layer_index;
      logic [FIRED_F_W-1:0] fired_count;
      logic [LAYER_E_W-1:0] layer_energy;
      logic [MAXB_F_W-1:0]  max_bar;
      logic [PEAK_W-1:0]    peak_ratio;
      logic [CENTRE_W-1:0]  centre_bar;
      logic [SPREAD_W-1:0]  spread;
      logic                 layer_valid;
      logic [SUM33_W-1:0]   range_energy;
      logic [SUM33_W-1:0]   event_energy;
      logic                 last;
   } layer_moments_type;

   // event store mirror and the queue of layer results still to come
   class shower_scoreboard;
      logic [ENERGY_BITS-1:0] bar_e [LAYERS][BARS];
      logic [BARS-1:0]        fired [LAYERS];
      longint unsigned        event_sum;
      bit                     drop_isolated;
      int                     first_l;
      int                     last_l;
      layer_moments_type      pending [$];
      int                     failures;

      function new();
         wipe_store();
         drop_isolated = 0;
         first_l = 0;
         last_l = 13;
         failures = 0;
      endfunction

      function void wipe_store();
         for (int l = 0; l < LAYERS; l++) begin
            fired[l] = '0;
            for (int b = 0; b < BARS; b++) bar_e[l][b] = '0;
         end
         event_sum = 0;
      endfunction

      function void set_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_DROP:  drop_isolated = val[0];
            CSR_FIRST: first_l = int'(val);
            CSR_LAST:  last_l = int'(val);
            default: ;
         endcase
      endfunction

      // moments of one layer; filtered energy sum handed back for the range sum
      function layer_moments_type layer_moments(int l, output longint unsigned sum_e);
         logic [BARS-1:0] raw, f;
         longint unsigned e, sum_be, best, c, acc, den, pos, d, q;
         bit found;
         int mb, cnt;
         layer_moments_type r;
         r = '{default: '0};
         raw = fired[l];
         f = drop_isolated ? (raw & ((raw << 1) | (raw >> 1))) : raw;
         sum_e = 0; sum_be = 0; best = 0; found = 0; mb = 0; cnt = 0;
         for (int b = 0; b < BARS; b++) begin
            e = bar_e[l][b];
            if (raw[b] && (!found || e > best)) begin
               best = e; mb = b; found = 1;
            end
            if (f[b]) begin
               cnt++;
               sum_e += e;
               sum_be += longint'(b) * e;
            end
         end
         r.layer_index = LAYER_F_W'(l);
         r.fired_count = FIRED_F_W'(cnt);
         r.layer_energy = LAYER_E_W'((sum_e > LAYER_E_MAX) ? LAYER_E_MAX : sum_e);
         r.max_bar = MAXB_F_W'(mb);
         r.last = (l == LAYERS - 1);
         if (found) begin
            den = best + ((mb < BARS - 1) ? longint'(bar_e[l][mb+1]) : 0)
                       + ((mb > 0) ? longint'(bar_e[l][mb-1]) : 0);
            r.peak_ratio = PEAK_W'((den != 0) ? (best << 16) / den : 0);
         end
         r.layer_valid = (cnt != 0);
         if (cnt != 0 && sum_e != 0) begin
            c = (sum_be << 8) / sum_e;
            r.centre_bar = CENTRE_W'((c > CENTRE_MAX) ? CENTRE_MAX : c);
            acc = 0;
            for (int b = 0; b < BARS; b++) begin
               if (f[b]) begin
                  pos = longint'(b) << 8;
                  d = (pos >= c) ? pos - c : c - pos;
                  acc += longint'(bar_e[l][b]) * (d * d);
               end
            end
            q = (acc / sum_e) >> 8;
            r.spread = SPREAD_W'((q > SPREAD_MAX) ? SPREAD_MAX : q);
         end
         return r;
      endfunction

      // accepted request item: update the store or queue the report results
      function void note_request(logic [OP_W-1:0] op, logic [3:0] lyr, logic [4:0] bar,
                                 logic [23:0] en);
         longint unsigned old_e, new_e, range_e, s;
         layer_moments_type r;
         case (op)
            OP_CLEAR: wipe_store();
            OP_ADD: begin
               if (lyr < LAYERS && bar < BARS) begin
                  old_e = bar_e[lyr][bar];
                  new_e = old_e + en;
                  if (new_e > (64'd1 << ENERGY_BITS) - 1) new_e = (64'd1 << ENERGY_BITS) - 1;
                  bar_e[lyr][bar] = ENERGY_BITS'(new_e);
                  fired[lyr][bar] = 1'b1;
                  event_sum += new_e - old_e;
                  if (event_sum > SUM33_MAX) event_sum = SUM33_MAX;
               end
            end
            OP_REPORT: begin
               range_e = 0;
               for (int l = 0; l < LAYERS; l++) begin
                  r = layer_moments(l, s);
                  if (l >= first_l && l <= last_l) range_e += s;
               end
               if (range_e > SUM33_MAX) range_e = SUM33_MAX;
               for (int l = 0; l < LAYERS; l++) begin
                  r = layer_moments(l, s);
                  r.range_energy = SUM33_W'(range_e);
                  r.event_energy = SUM33_W'(event_sum);
                  pending.insert(pending.size(), r);
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      // accepted result item against the oldest expected one
      function void check_result(layer_moments_type act);
         layer_moments_type want;
         if (pending.size() == 0) begin
            $error("unexpected result item for layer %0d", act.layer_index);
            failures++;
            return;
         end
         want = pending.pop_front();
         compare_field("layer_index", want.layer_index, act.layer_index);
         compare_field("fired_count", want.fired_count, act.fired_count);
         compare_field("layer_energy", want.layer_energy, act.layer_energy);
         compare_field("max_bar", want.max_bar, act.max_bar);
         compare_field("peak_ratio", want.peak_ratio, act.peak_ratio);
         compare_field("centre_bar", want.centre_bar, act.centre_bar);
         compare_field("spread", want.spread, act.spread);
         compare_field("layer_valid", want.layer_valid, act.layer_valid);
         compare_field("range_energy", want.range_energy, act.range_energy);
         compare_field("event_energy", want.event_energy, act.event_energy);
         compare_field("last", want.last, act.last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   shmu_req_if req_bus ();
   shmu_rsp_if rsp_bus ();

   calorimeter_layer_shower_moments_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   shower_scoreboard sb = new();
   bit calm;
   bit hold_now;
   int hold_left;
   int stall_left;
   longint unsigned cycles;
   int random_items;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: checks, random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result('{rsp_bus.layer_index, rsp_bus.fired_count, rsp_bus.layer_energy,
                              rsp_bus.max_bar, rsp_bus.peak_ratio, rsp_bus.centre_bar,
                              rsp_bus.spread, rsp_bus.layer_valid, rsp_bus.range_energy,
                              rsp_bus.event_energy, rsp_bus.last});
            stall_left = calm ? 0 : $urandom_range(0, 17);
         end
         if (hold_now) begin
            hold_left = 6000;
            hold_now = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // offer one request item after a random gap and wait for it to be taken
   task automatic send_item(logic [OP_W-1:0] op, logic [3:0] lyr, logic [4:0] bar,
                            logic [23:0] en);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.hit_layer <= lyr;
      req_bus.hit_bar <= bar;
      req_bus.hit_energy <= en;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(op, lyr, bar, en);
   endtask

   // wait for every expected result, then let queued hits and clears finish
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csrs(logic drop, logic [CFG_W-1:0] first_l, logic [CFG_W-1:0] last_l);
      logic [CFG_W-1:0] vals [3];
      vals = '{{3'b0, drop}, first_l, last_l};
      for (int i = 0; i < 3; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_csr(CSR_IDX_W'(i), vals[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // energy of random magnitude, now and then the largest value
   function automatic logic [23:0] draw_energy();
      int w;
      w = $urandom_range(0, 24);
      if ($urandom_range(0, 9) == 0) return 24'hFFFFFF;
      return 24'($urandom() & ((32'd1 << w) - 1));
   endfunction

   // one event: usually a clear, a cluster of hits with some noise, then a report
   task automatic send_event(int n_hits);
      int lyr, ctr, bar;
      if ($urandom_range(0, 5) != 0) begin
         send_item(OP_CLEAR, 4'($urandom()), 5'($urandom()), 24'($urandom()));
         random_items++;
      end
      for (int i = 0; i < n_hits; i++) begin
         case ($urandom_range(0, 19))
            0: send_item(OP_UNUSED, 4'($urandom()), 5'($urandom()), 24'($urandom()));
            1: send_item(OP_ADD, 4'($urandom_range(14, 15)), 5'($urandom()), 24'($urandom()));
            2: begin
               send_item(OP_ADD, 4'($urandom_range(0, 13)), 5'($urandom()), draw_energy());
               random_items++;
            end
            default: begin
               if (i == 0 || $urandom_range(0, 3) == 0) begin
                  lyr = $urandom_range(0, 13);
                  ctr = $urandom_range(0, 31);
               end
               bar = ctr + $urandom_range(0, 4) - 2;
               if (bar < 0) bar = 0;
               if (bar > 31) bar = 31;
               send_item(OP_ADD, 4'(lyr), 5'(bar), draw_energy());
               random_items++;
            end
         endcase
      end
      send_item(OP_REPORT, 4'($urandom()), 5'($urandom()), 24'($urandom()));
      random_items++;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_CLEAR;
      req_bus.hit_layer <= '0;
      req_bus.hit_bar <= '0;
      req_bus.hit_energy <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csrs(1'b0, 4'd0, 4'd13);

      // directed: empty store, saturation, edges, zero energy, ignored items
      calm = 1;
      send_item(OP_REPORT, 4'd0, 5'd0, 24'd0);
      send_item(OP_ADD, 4'd0, 5'd0, 24'hFFFFFF);
      send_item(OP_ADD, 4'd0, 5'd0, 24'hFFFFFF);
      send_item(OP_ADD, 4'd0, 5'd1, 24'd0);
      send_item(OP_ADD, 4'd0, 5'd31, 24'd1);
      send_item(OP_ADD, 4'd13, 5'd31, 24'hFFFFFF);
      send_item(OP_ADD, 4'd13, 5'd30, 24'd5);
      send_item(OP_ADD, 4'd13, 5'd10, 24'd7);
      send_item(OP_ADD, 4'd5, 5'd15, 24'd0);
      send_item(OP_ADD, 4'd14, 5'd3, 24'd9);
      send_item(OP_ADD, 4'd15, 5'd31, 24'd1);
      send_item(OP_UNUSED, 4'd15, 5'd31, 24'hFFFFFF);
      send_item(OP_ADD, 4'd7, 5'd20, 24'hAAAAAA);
      send_item(OP_ADD, 4'd7, 5'd21, 24'h555555);
      send_item(OP_ADD, 4'd9, 5'd4, 24'd100);
      send_item(OP_ADD, 4'd9, 5'd4, 24'd0);
      send_item(OP_REPORT, 4'd0, 5'd0, 24'd0);
      settle();
      write_csrs(1'b1, 4'd13, 4'd0);
      send_item(OP_REPORT, 4'd15, 5'd31, 24'hFFFFFF);
      settle();
      write_csrs(1'b1, 4'd0, 4'd15);
      send_item(OP_REPORT, 4'd0, 5'd0, 24'd0);
      send_item(OP_CLEAR, 4'd0, 5'd0, 24'd0);
      send_item(OP_REPORT, 4'd0, 5'd0, 24'd0);

      // random events, settings changed between some of them
      for (int ev = 0; random_items < 150; ev++) begin
         if (ev % 4 == 0) begin
            settle();
            write_csrs(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)));
         end
         calm = ($urandom_range(0, 3) == 0);
         // long result hold-off while hits keep coming behind a report
         if (ev == 2) begin
            calm = 1;
            hold_now = 1;
            send_event(6);
            send_event(10);
         end else begin
            send_event($urandom_range(1, 12));
         end
      end

      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
